/* src/abt_pkg.sv */
// abt_pkg: shared widths and controller/datapath interface structs
// for the abundant number test block
// no dependencies
package abt_pkg;

  // fixed field widths of the request and result channels
  localparam int unsigned NUMBER_FIELD_W = 32;
  localparam int unsigned SUM_FIELD_W    = 35;

  // default width of the number actually classified
  localparam int unsigned NUMBER_BITS_DEF = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture number, clear sum, divisor to one, start divide
    logic div_step;  // one restoring division step
    logic accum;     // add divisor pair, next divisor, restart divide
    logic fix;       // remove the number itself from the sum
    logic load_out;  // move finished result into the output register
  } abt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;  // final division step in progress
    logic stop;      // trial divisor passed the square root
  } abt_status_t;

endpackage

/* src/abt_datapath.sv */
// abt_datapath: held number, trial divisor, shift-subtract divider,
// running sum and output payload registers
// depends on abt_pkg
module abt_datapath #(
  parameter int unsigned NUMBER_BITS = abt_pkg::NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  abt_pkg::abt_cmd_t                   cmd,
  output abt_pkg::abt_status_t                status,
  input  logic [abt_pkg::NUMBER_FIELD_W-1:0]  in_number,
  output logic [abt_pkg::SUM_FIELD_W-1:0]     out_divisor_sum,
  output logic                                out_is_abundant
);
  import abt_pkg::*;

  localparam int unsigned SUM_W = NUMBER_BITS + 3;
  localparam int unsigned CNT_W = $clog2(NUMBER_BITS);

  logic [NUMBER_BITS-1:0] number_in;
  logic [NUMBER_BITS-1:0] number_r;
  logic [NUMBER_BITS-1:0] divisor_r, divisor_nxt;
  logic [NUMBER_BITS-1:0] quo_r, quo_nxt;
  logic [NUMBER_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SUM_FIELD_W-1:0] sum_field;
  logic [SUM_FIELD_W-1:0] out_sum_r;
  logic                   out_abundant_r;

  logic [NUMBER_BITS:0]   partial;
  logic [NUMBER_BITS:0]   divisor_ext;
  logic [NUMBER_BITS:0]   partial_diff;
  logic                   fits;
  logic                   exact;
  logic [SUM_W-1:0]       add_lo;
  logic [SUM_W-1:0]       add_hi;

  // fit the request field to the working width
  generate
    if (NUMBER_BITS >= NUMBER_FIELD_W) begin : g_num_ext
      assign number_in = NUMBER_BITS'(in_number);
    end else begin : g_num_cut
      assign number_in = in_number[NUMBER_BITS-1:0];
    end
  endgenerate

  // one restoring division step
  assign partial      = {rem_r, quo_r[NUMBER_BITS-1]};
  assign divisor_ext  = {1'b0, divisor_r};
  assign partial_diff = partial - divisor_ext;
  assign fits         = (partial >= divisor_ext);

  // divisor pair contribution
  assign exact  = (rem_r == '0);
  assign add_lo = exact ? SUM_W'(divisor_r) : '0;
  assign add_hi = (exact && (quo_r != divisor_r)) ? SUM_W'(quo_r) : '0;

  assign status.div_last = (cnt_r == CNT_W'(NUMBER_BITS - 1));
  assign status.stop     = (divisor_r > quo_r);

  // next values of the working registers
  always_comb begin
    divisor_nxt = divisor_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    if (cmd.load) begin
      divisor_nxt = NUMBER_BITS'(1);
      quo_nxt     = number_in;
      rem_nxt     = '0;
      cnt_nxt     = '0;
      sum_nxt     = '0;
    end else if (cmd.div_step) begin
      quo_nxt = {quo_r[NUMBER_BITS-2:0], fits};
      rem_nxt = fits ? partial_diff[NUMBER_BITS-1:0] : partial[NUMBER_BITS-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.accum) begin
      sum_nxt     = sum_r + add_lo + add_hi;
      divisor_nxt = divisor_r + NUMBER_BITS'(1);
      quo_nxt     = number_r;
      rem_nxt     = '0;
      cnt_nxt     = '0;
    end else if (cmd.fix) begin
      sum_nxt = sum_r - SUM_W'(number_r);
    end
  end

  // fit the full sum to the result field
  generate
    if (SUM_W >= SUM_FIELD_W) begin : g_sum_cut
      assign sum_field = sum_r[SUM_FIELD_W-1:0];
    end else begin : g_sum_ext
      assign sum_field = SUM_FIELD_W'(sum_r);
    end
  endgenerate

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      number_r <= number_in;
    end
    divisor_r <= divisor_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    sum_r     <= sum_nxt;
    if (cmd.load_out) begin
      out_sum_r      <= sum_field;
      out_abundant_r <= (sum_r > SUM_W'(number_r));
    end
  end

  assign out_divisor_sum = out_sum_r;
  assign out_is_abundant = out_abundant_r;

endmodule

/* src/abt_controller.sv */
// abt_controller: sequencing state machine and output valid flag
// for the abundant number test block
// depends on abt_pkg
module abt_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output abt_pkg::abt_cmd_t    cmd,
  input  abt_pkg::abt_status_t status
);
  import abt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TEST,
    ST_FIX,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state, commands and output flag
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.stop) begin
          state_nxt = ST_FIX;
        end else begin
          cmd.accum = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // wait until the output register is free
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/abundant_number_test_top.sv */
// one trial divisor per pass of the shift-subtract divider, followed by the test state, until
// the trial divisor passes the square root of the number
// throughput: one request at a time; the next request is taken while a result waits
// reset: synchronous active-low rst_n returns the controller to idle with no result pending
// depends on abt_pkg, abt_controller, abt_datapath
module abundant_number_test_top #(
  parameter int unsigned NUMBER_BITS = abt_pkg::NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [abt_pkg::NUMBER_FIELD_W-1:0]  in_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [abt_pkg::SUM_FIELD_W-1:0]     out_divisor_sum,
  output logic                                out_is_abundant
);
  import abt_pkg::*;

  abt_cmd_t    cmd;
  abt_status_t status;

  // sequencing
  abt_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // divider, sum and result registers
  abt_datapath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .status          (status),
    .in_number       (in_number),
    .out_divisor_sum (out_divisor_sum),
    .out_is_abundant (out_is_abundant)
  );

endmodule

/* dv/abt_aliquot_checker.sv */
// abt_aliquot_checker: watches the request and result channels of the abundant number test
// block, predicts each divisor sum and abundance flag, and compares them in order
// depends on abt_pkg for the channel field widths
module abt_aliquot_checker #(
  parameter int unsigned NUMBER_BITS = abt_pkg::NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [abt_pkg::NUMBER_FIELD_W-1:0]  in_number,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [abt_pkg::SUM_FIELD_W-1:0]     out_divisor_sum,
  input  logic                                out_is_abundant,
  output int                                  pending,
  output int                                  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [abt_pkg::SUM_FIELD_W-1:0] divisor_sum;
    logic                            is_abundant;
  } aliquot_t;

  aliquot_t aliquot_q[$];

  // aliquot sum by trial division up to the square root, cofactors included
  function automatic aliquot_t predict_aliquot(input logic [abt_pkg::NUMBER_FIELD_W-1:0] raw);
    longint unsigned mask;
    longint unsigned n;
    longint unsigned d;
    longint unsigned co;
    longint unsigned total;
    aliquot_t        r;
    mask  = (NUMBER_BITS >= 64) ? '1 : ((64'd1 << NUMBER_BITS) - 64'd1);
    n     = longint'(raw) & mask;
    total = 0;
    if (n >= 1) begin
      for (d = 1; d <= n / d; d++) begin
        if (n % d == 0) begin
          co    = n / d;
          total = total + d;
          if (co != d) begin
            total = total + co;
          end
        end
      end
      // divisor one pairs with the number itself, which is not proper
      total = total - n;
    end
    r.divisor_sum = total[abt_pkg::SUM_FIELD_W-1:0];
    r.is_abundant = (total > n);
    return r;
  endfunction

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // compare results first, then queue the prediction for a new request
  always @(posedge clk) begin
    aliquot_t exp_r;
    if (!rst_n) begin
      aliquot_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (aliquot_q.size() == 0) begin
          $error("result with no request outstanding: divisor_sum %0d is_abundant %0d",
                 out_divisor_sum, out_is_abundant);
          fail_count++;
        end else begin
          exp_r = aliquot_q.pop_front();
          if (out_divisor_sum !== exp_r.divisor_sum) begin
            $error("divisor_sum mismatch: expected %0d, actual %0d",
                   exp_r.divisor_sum, out_divisor_sum);
            fail_count++;
          end
          if (out_is_abundant !== exp_r.is_abundant) begin
            $error("is_abundant mismatch: expected %0d, actual %0d",
                   exp_r.is_abundant, out_is_abundant);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        aliquot_q = {aliquot_q, predict_aliquot(in_number)};
      end
    end
    pending = aliquot_q.size();
  end

endmodule

/* dv/tb_abundant_number_test_top.sv */
// tb_abundant_number_test_top: clock, reset, request stimulus and result back-pressure for
// the abundant number test block, with the verdict taken from abt_aliquot_checker
// depends on abt_pkg, abundant_number_test_top, abt_aliquot_checker
module tb_abundant_number_test_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_W = abt_pkg::NUMBER_FIELD_W;
  localparam int unsigned SUM_W = abt_pkg::SUM_FIELD_W;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned RANDOM_PER_PHASE = 20;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [NUM_W-1:0] in_number;
  logic             out_valid;
  logic             out_ready;
  logic [SUM_W-1:0] out_divisor_sum;
  logic             out_is_abundant;
  int               pending;
  int               fail_count;

  int               send_idle_pct;
  int               recv_stall_pct;
  longint unsigned  cycle_count;

  abundant_number_test_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number       (in_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_divisor_sum (out_divisor_sum),
    .out_is_abundant (out_is_abundant)
  );

  abt_aliquot_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number       (in_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_divisor_sum (out_divisor_sum),
    .out_is_abundant (out_is_abundant),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one request, entered and left at a falling edge
  task automatic send_number(input logic [NUM_W-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= n;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly small numbers keep the trial division short
  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      return NUM_W'($urandom_range(4095));
    end else if (sel < 75) begin
      return NUM_W'(12 * $urandom_range(400));
    end else if (sel < 93) begin
      return NUM_W'($urandom_range(65535));
    end else begin
      return NUM_W'($urandom_range(1 << 20));
    end
  endfunction

  initial begin
    logic [NUM_W-1:0] directed_q[$];
    int               phase;
    int               k;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_number      = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero, one, small primes, perfect, abundant, odd abundant, power of two, all ones
    directed_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd18, 32'd20,
                   32'd24, 32'd28, 32'd30, 32'd36, 32'd496, 32'd945, 32'd5040, 32'd8128,
                   32'd55440, 32'd65521, 32'd65536, 32'hFFFF_FFFF};
    foreach (directed_q[i]) begin
      send_number(directed_q[i]);
    end
    drain_results();

    // random requests over the idle and stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (k == RANDOM_PER_PHASE / 2) begin
          drain_results();
        end
        send_number(pick_number());
      end
    end
    in_valid <= 1'b0;

    // wait out the last results, then settle
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* abundant_number_test_top.f */
src/abt_pkg.sv
src/abt_datapath.sv
src/abt_controller.sv
src/abundant_number_test_top.sv
dv/abt_aliquot_checker.sv
dv/tb_abundant_number_test_top.sv
